>>> rtl/core/i2cps_pkg.sv
package i2cps_pkg;

  // Longest read a transaction may ask for
  localparam int MAX_READ_BYTES = 16;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Transaction mode
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_WRITE = 3'b010,
    MODE_READ  = 3'b100
  } mode_t;

  // Pin phase sequencer, one phase per tick
  typedef enum logic [23:0] {
    PH_START0 = 24'h000001,
    PH_START1 = 24'h000002,
    PH_START2 = 24'h000004,
    PH_START3 = 24'h000008,
    PH_TX0    = 24'h000010,
    PH_TX1    = 24'h000020,
    PH_TX2    = 24'h000040,
    PH_TX3    = 24'h000080,
    PH_RACK0  = 24'h000100,
    PH_RACK1  = 24'h000200,
    PH_RACK2  = 24'h000400,
    PH_RACK3  = 24'h000800,
    PH_RX0    = 24'h001000,
    PH_RX1    = 24'h002000,
    PH_RX2    = 24'h004000,
    PH_RX3    = 24'h008000,
    PH_SACK0  = 24'h010000,
    PH_SACK1  = 24'h020000,
    PH_SACK2  = 24'h040000,
    PH_SACK3  = 24'h080000,
    PH_STOP0  = 24'h100000,
    PH_STOP1  = 24'h200000,
    PH_STOP2  = 24'h400000,
    PH_STOP3  = 24'h800000
  } phase_t;

  // One input word
  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] device_address;
    logic [7:0] command_byte;
    logic [4:0] read_length;
    logic       sda_in;
  } item_t;

  // One result word
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       ack_seen;
    logic       ack_valid;
    logic       last;
  } res_t;

endpackage

>>> rtl/core/i2cps_engine.sv
module i2cps_engine
  import i2cps_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  output res_t  res
);

  mode_t      mode_r, mode_nxt;
  phase_t     phase_r, phase_nxt;
  logic [2:0] bit_idx_r, bit_idx_nxt;
  logic [4:0] bytes_done_r, bytes_done_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] held_cmd_r, held_cmd_nxt;
  logic [4:0] held_len_r, held_len_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;

  // Next state and result for the word at hand
  always_comb begin
    logic [4:0] len;
    logic [5:0] bytes_inc;
    logic       start;
    phase_t     ph;

    mode_nxt       = mode_r;
    phase_nxt      = phase_r;
    bit_idx_nxt    = bit_idx_r;
    bytes_done_nxt = bytes_done_r;
    shift_nxt      = shift_r;
    held_cmd_nxt   = held_cmd_r;
    held_len_nxt   = held_len_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    res            = '0;

    // latch a new transaction; its first phase runs this same tick
    start = (mode_r == MODE_IDLE) &&
            (item.cmd == CMD_WRITE || item.cmd == CMD_READ);
    len = item.read_length;
    if (len == 5'd0) begin
      len = 5'd1;
    end
    if (len > 5'(MAX_READ_BYTES)) begin
      len = 5'(MAX_READ_BYTES);
    end
    if (start) begin
      held_cmd_nxt   = item.command_byte;
      held_len_nxt   = len;
      mode_nxt       = (item.cmd == CMD_WRITE) ? MODE_WRITE : MODE_READ;
      phase_nxt      = PH_START0;
      bit_idx_nxt    = 3'd0;
      bytes_done_nxt = 5'd0;
      shift_nxt      = {item.device_address, item.cmd == CMD_READ};
    end

    ph        = phase_nxt;
    bytes_inc = {1'b0, bytes_done_nxt} + 6'd1;
    res.busy_res = (mode_nxt != MODE_IDLE);

    if (mode_nxt != MODE_IDLE) begin
      phase_nxt = phase_t'({ph[22:0], 1'b0});
      case (ph)
        PH_START0: sda_nxt = 1'b1;
        PH_START1: scl_nxt = 1'b1;
        PH_START2: sda_nxt = 1'b0;
        PH_START3: scl_nxt = 1'b0;
        // send byte
        PH_TX0: begin
          scl_nxt     = 1'b0;
          bit_idx_nxt = 3'd0;
        end
        PH_TX1: sda_nxt = shift_nxt[7];
        PH_TX2: scl_nxt = 1'b1;
        PH_TX3: begin
          scl_nxt   = 1'b0;
          shift_nxt = {shift_nxt[6:0], 1'b0};
          if (bit_idx_nxt != 3'd7) begin
            bit_idx_nxt = bit_idx_nxt + 3'd1;
            phase_nxt   = PH_TX1;
          end else begin
            bit_idx_nxt = 3'd0;
            phase_nxt   = PH_RACK0;
          end
        end
        // ack from target
        PH_RACK0: scl_nxt = 1'b0;
        PH_RACK1: sda_nxt = 1'b1;
        PH_RACK2: begin
          scl_nxt       = 1'b1;
          res.ack_seen  = item.sda_in;
          res.ack_valid = 1'b1;
        end
        PH_RACK3: begin
          scl_nxt = 1'b0;
          if (mode_nxt == MODE_WRITE) begin
            if (bytes_done_nxt == 5'd0) begin
              bytes_done_nxt = 5'd1;
              shift_nxt      = held_cmd_nxt;
              phase_nxt      = PH_TX0;
            end else begin
              phase_nxt = PH_STOP0;
            end
          end else begin
            bytes_done_nxt = 5'd0;
            phase_nxt      = PH_RX0;
          end
        end
        // receive byte
        PH_RX0: begin
          scl_nxt     = 1'b0;
          bit_idx_nxt = 3'd0;
          shift_nxt   = 8'd0;
        end
        PH_RX1: sda_nxt = 1'b1;
        PH_RX2: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_nxt[6:0], item.sda_in};
          if (bit_idx_nxt == 3'd7) begin
            res.read_byte  = shift_nxt;
            res.read_valid = 1'b1;
          end
        end
        PH_RX3: begin
          scl_nxt = 1'b0;
          if (bit_idx_nxt != 3'd7) begin
            bit_idx_nxt = bit_idx_nxt + 3'd1;
            phase_nxt   = PH_RX2;
          end else begin
            bit_idx_nxt = 3'd0;
            phase_nxt   = PH_SACK0;
          end
        end
        // ack from master, NACK on the final byte
        PH_SACK0: scl_nxt = 1'b0;
        PH_SACK1: sda_nxt = (bytes_inc >= {1'b0, held_len_nxt});
        PH_SACK2: scl_nxt = 1'b1;
        PH_SACK3: begin
          scl_nxt        = 1'b0;
          bytes_done_nxt = bytes_inc[4:0];
          phase_nxt      = (bytes_inc >= {1'b0, held_len_nxt}) ? PH_STOP0 : PH_RX0;
        end
        // stop
        PH_STOP0: scl_nxt = 1'b0;
        PH_STOP1: sda_nxt = 1'b0;
        PH_STOP2: scl_nxt = 1'b1;
        PH_STOP3: begin
          sda_nxt        = 1'b1;
          res.last       = 1'b1;
          mode_nxt       = MODE_IDLE;
          phase_nxt      = PH_START0;
          bit_idx_nxt    = 3'd0;
          bytes_done_nxt = 5'd0;
        end
        default: begin
          mode_nxt       = MODE_IDLE;
          phase_nxt      = PH_START0;
          bit_idx_nxt    = 3'd0;
          bytes_done_nxt = 5'd0;
        end
      endcase
    end

    res.scl = scl_nxt;
    res.sda = sda_nxt;
  end

  // Sequencer state, advanced once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      phase_r      <= PH_START0;
      bit_idx_r    <= 3'd0;
      bytes_done_r <= 5'd0;
      shift_r      <= 8'd0;
      held_cmd_r   <= 8'd0;
      held_len_r   <= 5'd1;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
    end else if (fire) begin
      mode_r       <= mode_nxt;
      phase_r      <= phase_nxt;
      bit_idx_r    <= bit_idx_nxt;
      bytes_done_r <= bytes_done_nxt;
      shift_r      <= shift_nxt;
      held_cmd_r   <= held_cmd_nxt;
      held_len_r   <= held_len_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
    end
  end

  // Checks
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.last |-> res.busy_res)
    else $error("end of transaction flagged while not busy");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.ack_valid && res.read_valid))
    else $error("ack and read byte flagged on one tick");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.last |=> mode_r == MODE_IDLE && phase_r == PH_START0)
    else $error("sequencer not idle after stop");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE |-> bit_idx_r == 3'd0 && bytes_done_r == 5'd0)
    else $error("counters left set while idle");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_len_r != 5'd0 && held_len_r <= 5'(MAX_READ_BYTES))
    else $error("held read length out of range");

endmodule

>>> rtl/core/i2c_master_phase_sequencer.sv
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall  cmd, device_address, command_byte,
//                                        read_length, sda_in
// out_     output     out_valid/out_stall scl, sda, busy_res, read_byte,
//                                        read_valid, ack_seen, ack_valid, last
//
// One result word per input word; one word per cycle sustained while out_stall is low.
// A word goes through the input register, then the sequencer step into
// the output register.
// Synchronous active-low reset: idle, both lines released high.
// A stalled output holds its word; the input register still takes one
// more word, after which in_stall follows out_stall.
module i2c_master_phase_sequencer
  import i2cps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [6:0] in_device_address,
  input  logic [7:0] in_command_byte,
  input  logic [4:0] in_read_length,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl,
  output logic       out_sda,
  output logic       out_busy_res,
  output logic [7:0] out_read_byte,
  output logic       out_read_valid,
  output logic       out_ack_seen,
  output logic       out_ack_valid,
  output logic       out_last
);

  logic  in_vld_r;
  item_t in_item_r;
  logic  out_vld_r;
  res_t  out_res_r;
  res_t  step_res;
  logic  fire;

  // Step the sequencer when a word waits and the output slot is free
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= '{cmd: in_cmd, device_address: in_device_address,
                     command_byte: in_command_byte, read_length: in_read_length,
                     sda_in: in_sda_in};
    end
  end

  i2cps_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .res   (step_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_scl        = out_res_r.scl;
  assign out_sda        = out_res_r.sda;
  assign out_busy_res   = out_res_r.busy_res;
  assign out_read_byte  = out_res_r.read_byte;
  assign out_read_valid = out_res_r.read_valid;
  assign out_ack_seen   = out_res_r.ack_seen;
  assign out_ack_valid  = out_res_r.ack_valid;
  assign out_last       = out_res_r.last;

endmodule
